>>> rtl/core/cht_pkg.sv
// Shared types, constants and command/status structs for the chained hash table.
package cht_pkg;

  localparam int DEF_BUCKETS = 32;
  localparam int DEF_POOL = 32;
  localparam int MAX_OUT = 32;

  localparam int TS_W = 6;
  localparam int KEY_W = 16;
  localparam int NAME_W = 8;
  localparam int ORDER_W = 16;
  localparam int STATUS_W = 2;
  localparam int BIDX_W = 5;
  localparam int REC_W = KEY_W + NAME_W + ORDER_W;

  localparam logic [TS_W-1:0] TABLE_SIZE_RESET = TS_W'(30);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DUMP   = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DUMPED   = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    PUSH_RESP = 1'b0,
    PUSH_PEND = 1'b1
  } push_sel_t;

  typedef struct packed {
    logic      accept;
    logic      load;
    logic      mod_step;
    logic      ins_write;
    logic      head_set;
    logic      link_set;
    logic      used_inc;
    logic      cur_from_head;
    logic      cur_from_link;
    logic      bkt_clear;
    logic      bkt_inc;
    logic      capture;
    logic      push;
    push_sel_t push_sel;
    status_t   push_status;
    logic      push_last;
  } cht_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_dump;
    logic mod_last;
    logic full;
    logic head_ok;
    logic bkt_end;
    logic link_ok;
    logic pend_valid;
    logic can_push;
    logic cap_last;
  } cht_stat_t;

endpackage

>>> rtl/core/cht_if.sv
// Channel interfaces: input items, result items and the configuration write.
interface cht_item_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [cht_pkg::KEY_W-1:0]    record_key;
  logic [cht_pkg::NAME_W-1:0]   record_name;
  logic [cht_pkg::ORDER_W-1:0]  record_order;

  modport source (output valid, cmd, record_key, record_name, record_order, input ready);
  modport sink (input valid, cmd, record_key, record_name, record_order, output ready);
endinterface

interface cht_result_if;
  logic                          valid;
  logic                          ready;
  logic [cht_pkg::STATUS_W-1:0]  status;
  logic [cht_pkg::BIDX_W-1:0]    bucket_index;
  logic [cht_pkg::KEY_W-1:0]     out_key;
  logic [cht_pkg::NAME_W-1:0]    out_name;
  logic [cht_pkg::ORDER_W-1:0]   out_order;
  logic                          last_result;

  modport source (output valid, status, bucket_index, out_key, out_name, out_order,
                  last_result, input ready);
  modport sink (input valid, status, bucket_index, out_key, out_name, out_order,
                last_result, output ready);
endinterface

interface cht_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [cht_pkg::TS_W-1:0]  table_size;

  modport source (output valid, table_size, input ready);
  modport sink (input valid, table_size, output ready);
endinterface

>>> rtl/core/chained_hash_table_core.sv
// Top level of the chained hash table: controller plus datapath.
//
// item_in carries one item per valid/ready handshake: an insert (cmd 0) with key,
// name and order, or a dump (cmd 1). result_out delivers result items with a
// last_result marker on the final one of each item. The user must write table_size
// through cfg only while idle; the block itself does not enforce this. Insert: an
// accept step, a bit-serial key modulo, then a walk to the chain tail with one link
// memory read per step, then the result; an empty bucket takes the record as head.
// Dump: the sweep visits every bucket in use, reads the head of each non-empty
// bucket, then each record and its link from the pool memories, and ends with the
// final result; the sweep is the rate limit.
// One item is in work at a time; item_in.ready is high only between items, and an
// item is taken while the previous final result still waits in the output register.
// When result_out stalls the controller holds its state until the output register
// frees. Reset clears the bucket valid flags, the pool count and the output register;
// no clearing pass runs and table_size returns to 30.
module chained_hash_table_core #(
  parameter int BUCKETS = cht_pkg::DEF_BUCKETS,
  parameter int POOL = cht_pkg::DEF_POOL
) (
  input  logic         clk,
  input  logic         rst,
  cht_item_if.sink     item_in,
  cht_result_if.source result_out,
  cht_cfg_if.sink      cfg
);

  cht_pkg::cht_cmd_t  cmd;
  cht_pkg::cht_stat_t stat;

  cht_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .stat(stat),
    .cmd (cmd)
  );

  cht_datapath #(.BUCKETS(BUCKETS), .POOL(POOL)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item_in   (item_in),
    .result_out(result_out),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> rtl/core/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/cht_datapath.sv
// Datapath: config register, modulo unit, pool memories, chain cursor and output register.
module cht_datapath #(
  parameter int BUCKETS = cht_pkg::DEF_BUCKETS,
  parameter int POOL = cht_pkg::DEF_POOL
) (
  input  logic              clk,
  input  logic              rst,
  cht_item_if.sink          item_in,
  cht_result_if.source      result_out,
  cht_cfg_if.sink           cfg,
  input  cht_pkg::cht_cmd_t cmd,
  output cht_pkg::cht_stat_t stat
);

  localparam int IW = $clog2(POOL);
  localparam int BW = $clog2(BUCKETS);
  localparam int UW = $clog2(POOL + 1);
  localparam int NW = $clog2(cht_pkg::MAX_OUT + 1);
  localparam int CW = $clog2(cht_pkg::KEY_W);
  localparam int TS_W = cht_pkg::TS_W;
  localparam int KEY_W = cht_pkg::KEY_W;
  localparam int NAME_W = cht_pkg::NAME_W;
  localparam int ORDER_W = cht_pkg::ORDER_W;
  localparam int REC_W = cht_pkg::REC_W;
  localparam int BIDX_W = cht_pkg::BIDX_W;

  logic [TS_W-1:0]    table_size;
  logic [TS_W-1:0]    nb;
  logic [KEY_W-1:0]   key_q;
  logic [NAME_W-1:0]  name_q;
  logic [ORDER_W-1:0] order_q;
  logic [KEY_W-1:0]   shift;
  logic [CW-1:0]      mcnt;
  logic [TS_W-1:0]    bucket;
  logic [TS_W-1:0]    rem_sh;
  logic [TS_W-1:0]    rem_next;
  logic [UW-1:0]      used;
  logic [IW-1:0]      slot;
  logic [BUCKETS-1:0] head_ok;
  logic [BW-1:0]      bidx;
  logic [IW-1:0]      cur;
  logic [NW-1:0]      n;

  logic [IW-1:0]      head_rdata;
  logic               link_we;
  logic [IW-1:0]      link_waddr;
  logic [IW:0]        link_wdata;
  logic [IW:0]        link_rdata;
  logic [REC_W-1:0]   rec_rdata;

  logic               pend_valid;
  logic [BIDX_W-1:0]  pend_bucket;
  logic [REC_W-1:0]   pend_rec;

  logic                      res_valid;
  cht_pkg::status_t          res_status;
  logic [BIDX_W-1:0]         res_bucket;
  logic [REC_W-1:0]          res_rec;
  logic                      res_last;
  logic                      can_push;

  always_comb begin
    priority if (table_size == '0) begin
      nb = TS_W'(1);
    end else if (table_size > TS_W'(BUCKETS)) begin
      nb = TS_W'(BUCKETS);
    end else begin
      nb = table_size;
    end
  end

  assign rem_sh = {bucket[TS_W-2:0], shift[KEY_W-1]};
  assign rem_next = (rem_sh >= nb) ? rem_sh - nb : rem_sh;
  assign slot = used[IW-1:0];
  assign bidx = bucket[BW-1:0];
  assign can_push = !res_valid || result_out.ready;

  assign cfg.ready = !rst;
  assign item_in.ready = cmd.accept && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= cht_pkg::TABLE_SIZE_RESET;
    end else if (cfg.valid) begin
      table_size <= cfg.table_size;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && item_in.valid) begin
      key_q <= item_in.record_key;
      name_q <= item_in.record_name;
      order_q <= item_in.record_order;
      shift <= item_in.record_key;
      mcnt <= '0;
    end else if (cmd.mod_step) begin
      shift <= {shift[KEY_W-2:0], 1'b0};
      mcnt <= mcnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bkt_clear || (cmd.load && item_in.valid)) begin
      bucket <= '0;
    end else if (cmd.mod_step) begin
      bucket <= rem_next;
    end else if (cmd.bkt_inc) begin
      bucket <= bucket + TS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      head_ok <= '0;
    end else begin
      if (cmd.used_inc) begin
        used <= used + UW'(1);
      end
      if (cmd.head_set) begin
        head_ok[bidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cur_from_head) begin
      cur <= head_rdata;
    end else if (cmd.cur_from_link) begin
      cur <= link_rdata[IW-1:0];
    end
  end

  assign link_we = cmd.ins_write || cmd.link_set;
  assign link_waddr = cmd.link_set ? cur : slot;
  assign link_wdata = cmd.link_set ? {1'b1, slot} : '0;

  cht_ram #(.WIDTH(IW), .DEPTH(BUCKETS)) u_head_ram (
    .clk  (clk),
    .we   (cmd.head_set),
    .waddr(bidx),
    .wdata(slot),
    .raddr(bidx),
    .rdata(head_rdata)
  );

  cht_ram #(.WIDTH(IW + 1), .DEPTH(POOL)) u_link_ram (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .raddr(cur),
    .rdata(link_rdata)
  );

  cht_ram #(.WIDTH(REC_W), .DEPTH(POOL)) u_rec_ram (
    .clk  (clk),
    .we   (cmd.ins_write),
    .waddr(slot),
    .wdata({key_q, name_q, order_q}),
    .raddr(cur),
    .rdata(rec_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      n <= '0;
    end else if (cmd.bkt_clear) begin
      pend_valid <= 1'b0;
      n <= '0;
    end else if (cmd.capture) begin
      pend_valid <= 1'b1;
      n <= n + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pend_bucket <= bucket[BIDX_W-1:0];
      pend_rec <= rec_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.push) begin
      res_valid <= 1'b1;
    end else if (result_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      res_last <= cmd.push_last;
      unique case (cmd.push_sel)
        cht_pkg::PUSH_PEND: begin
          res_status <= cht_pkg::ST_DUMPED;
          res_bucket <= pend_bucket;
          res_rec <= pend_rec;
        end
        cht_pkg::PUSH_RESP: begin
          res_status <= cmd.push_status;
          res_bucket <= (cmd.push_status == cht_pkg::ST_EMPTY) ? '0 : bucket[BIDX_W-1:0];
          res_rec <= '0;
        end
        default: begin
          res_status <= cmd.push_status;
          res_bucket <= '0;
          res_rec <= '0;
        end
      endcase
    end
  end

  assign result_out.valid = res_valid;
  assign result_out.status = res_status;
  assign result_out.bucket_index = res_bucket;
  assign result_out.out_key = res_rec[REC_W-1 -: KEY_W];
  assign result_out.out_name = res_rec[ORDER_W +: NAME_W];
  assign result_out.out_order = res_rec[ORDER_W-1:0];
  assign result_out.last_result = res_last;

  always_comb begin
    stat.in_valid = item_in.valid;
    stat.in_dump = (item_in.cmd == cht_pkg::CMD_DUMP);
    stat.mod_last = (mcnt == CW'(KEY_W - 1));
    stat.full = (used == UW'(POOL));
    stat.head_ok = head_ok[bidx];
    stat.bkt_end = (bucket >= nb);
    stat.link_ok = link_rdata[IW];
    stat.pend_valid = pend_valid;
    stat.can_push = can_push;
    stat.cap_last = (n == NW'(cht_pkg::MAX_OUT - 1));
  end

endmodule

>>> rtl/core/cht_ctrl.sv
// Controller: sequences modulo, chain walk on insert and the table sweep on dump.
module cht_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  cht_pkg::cht_stat_t stat,
  output cht_pkg::cht_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_INS_CHECK,
    S_INS_HEAD,
    S_INS_LREQ,
    S_INS_LCHK,
    S_INS_ACK,
    S_INS_FULL,
    S_DMP_BKT,
    S_DMP_HEAD,
    S_DMP_LREQ,
    S_DMP_REC,
    S_DMP_END
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.push_sel = cht_pkg::PUSH_RESP;
    cmd.push_status = cht_pkg::ST_INSERTED;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.accept = 1'b1;
        if (stat.in_valid) begin
          cmd.load = 1'b1;
          if (stat.in_dump) begin
            cmd.bkt_clear = 1'b1;
            state_next = S_DMP_BKT;
          end else begin
            state_next = S_MOD;
          end
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_next = S_INS_CHECK;
        end
      end
      S_INS_CHECK: begin
        priority if (stat.full) begin
          state_next = S_INS_FULL;
        end else if (stat.head_ok) begin
          cmd.ins_write = 1'b1;
          state_next = S_INS_HEAD;
        end else begin
          cmd.ins_write = 1'b1;
          cmd.head_set = 1'b1;
          cmd.used_inc = 1'b1;
          state_next = S_INS_ACK;
        end
      end
      S_INS_HEAD: begin
        cmd.cur_from_head = 1'b1;
        state_next = S_INS_LREQ;
      end
      S_INS_LREQ: begin
        state_next = S_INS_LCHK;
      end
      S_INS_LCHK: begin
        if (stat.link_ok) begin
          cmd.cur_from_link = 1'b1;
          state_next = S_INS_LREQ;
        end else begin
          cmd.link_set = 1'b1;
          cmd.used_inc = 1'b1;
          state_next = S_INS_ACK;
        end
      end
      S_INS_ACK: begin
        if (stat.can_push) begin
          cmd.push = 1'b1;
          cmd.push_status = cht_pkg::ST_INSERTED;
          cmd.push_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_INS_FULL: begin
        if (stat.can_push) begin
          cmd.push = 1'b1;
          cmd.push_status = cht_pkg::ST_FULL;
          cmd.push_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DMP_BKT: begin
        priority if (stat.bkt_end) begin
          state_next = S_DMP_END;
        end else if (stat.head_ok) begin
          state_next = S_DMP_HEAD;
        end else begin
          cmd.bkt_inc = 1'b1;
        end
      end
      S_DMP_HEAD: begin
        cmd.cur_from_head = 1'b1;
        state_next = S_DMP_LREQ;
      end
      S_DMP_LREQ: begin
        state_next = S_DMP_REC;
      end
      S_DMP_REC: begin
        if (!stat.pend_valid || stat.can_push) begin
          cmd.capture = 1'b1;
          cmd.push = stat.pend_valid;
          cmd.push_sel = cht_pkg::PUSH_PEND;
          cmd.push_status = cht_pkg::ST_DUMPED;
          priority if (stat.cap_last) begin
            state_next = S_DMP_END;
          end else if (stat.link_ok) begin
            cmd.cur_from_link = 1'b1;
            state_next = S_DMP_LREQ;
          end else begin
            cmd.bkt_inc = 1'b1;
            state_next = S_DMP_BKT;
          end
        end
      end
      S_DMP_END: begin
        if (stat.can_push) begin
          cmd.push = 1'b1;
          cmd.push_last = 1'b1;
          if (stat.pend_valid) begin
            cmd.push_sel = cht_pkg::PUSH_PEND;
            cmd.push_status = cht_pkg::ST_DUMPED;
          end else begin
            cmd.push_status = cht_pkg::ST_EMPTY;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/cht_checker.sv
// Port-level assertions for the chained hash table and their bind to the top level.
module cht_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cht_pkg::STATUS_W-1:0]  status,
  input logic [cht_pkg::BIDX_W-1:0]    bucket_index,
  input logic [cht_pkg::KEY_W-1:0]     out_key,
  input logic [cht_pkg::NAME_W-1:0]    out_name,
  input logic [cht_pkg::ORDER_W-1:0]   out_order,
  input logic                          last_result
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(bucket_index)
      && $stable(out_key) && $stable(out_name) && $stable(out_order) && $stable(last_result))
    else $error("stalled result changed");

  a_busy_mid_dump: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_result |-> !in_ready)
    else $error("item taken before dump finished");

  a_single_result_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != cht_pkg::ST_DUMPED) |->
      last_result && out_key == '0 && out_name == '0 && out_order == '0)
    else $error("status result with data or without last marker");

  a_empty_bucket: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == cht_pkg::ST_EMPTY) |-> bucket_index == '0)
    else $error("empty result with nonzero bucket");

endmodule

bind chained_hash_table_core cht_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (item_in.ready),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .status      (result_out.status),
  .bucket_index(result_out.bucket_index),
  .out_key     (result_out.out_key),
  .out_name    (result_out.out_name),
  .out_order   (result_out.out_order),
  .last_result (result_out.last_result)
);
